>>> sv/slbh_pkg.sv
// ----------------------------------------------------------------------------
// slbh_pkg
// Shared types, codes and mode tables for the status LED / button hold block.
// ----------------------------------------------------------------------------
package slbh_pkg;

    typedef enum logic [2:0] {
        MODE_PAIRING   = 3'd0,
        MODE_CONNECTED = 3'd1,
        MODE_IDLE      = 3'd2,
        MODE_FAULT     = 3'd3,
        MODE_PRESS     = 3'd4,
        MODE_DONE      = 3'd5
    } mode_t;

    typedef enum logic [1:0] {
        COLOR_BLUE  = 2'd0,
        COLOR_RED   = 2'd1,
        COLOR_GREEN = 2'd2,
        COLOR_WHITE = 2'd3
    } color_t;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_SET  = 1'b1
    } kind_t;

    localparam logic [2:0]  MODE_LAST  = 3'd5;
    localparam logic [6:0]  FULL_ON    = 7'd100;
    localparam logic [6:0]  FULL_OFF   = 7'd0;
    localparam logic [15:0] HOLD_RESET = 16'd100;
    localparam logic [15:0] COUNT_MAX  = 16'hFFFF;
    localparam int          MASK_BITS  = 4;

    typedef struct packed {
        kind_t      kind;
        logic       timer_flag;
        logic       button_level;
        logic [2:0] new_mode;
    } item_t;

    typedef struct packed {
        logic [6:0] brightness;
        color_t     color;
        logic       clear_owner;
        mode_t      mode;
    } result_t;

    // Blink mask per mode; brightness is on when all mask bits of the counter are set.
    function automatic logic [MASK_BITS-1:0] mode_mask(input mode_t m);
        logic [MASK_BITS-1:0] mask;
        unique case (m)
            MODE_PAIRING:   mask = 4'b1000;
            MODE_CONNECTED: mask = 4'b0000;
            MODE_IDLE:      mask = 4'b0100;
            MODE_FAULT:     mask = 4'b0000;
            MODE_PRESS:     mask = 4'b0010;
            MODE_DONE:      mask = 4'b0001;
            default:        mask = 4'b0100;
        endcase
        return mask;
    endfunction

    function automatic color_t mode_color(input mode_t m);
        color_t c;
        unique case (m)
            MODE_FAULT: c = COLOR_RED;
            MODE_PRESS: c = COLOR_GREEN;
            MODE_DONE:  c = COLOR_WHITE;
            default:    c = COLOR_BLUE;
        endcase
        return c;
    endfunction

endpackage

>>> sv/slbh_core.sv
// ----------------------------------------------------------------------------
// slbh_core
// Mode, long-press and blink state; computes one result per presented item.
// ----------------------------------------------------------------------------
module slbh_core import slbh_pkg::*; #(
    parameter int BLINK_BITS = 8,
    parameter int DONE_TICKS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        item_fire,
    input  item_t       item,
    output result_t     result
);

    localparam logic [15:0]           DONE_LIMIT = 16'(DONE_TICKS);
    localparam logic [BLINK_BITS-1:0] BLINK_ONE  = BLINK_BITS'(1);

    logic [15:0]           hold_ticks_reg;
    mode_t                 link_mode_reg,   link_mode_next;
    mode_t                 saved_mode_reg,  saved_mode_next;
    logic                  tick_phase_reg,  tick_phase_next;
    logic [BLINK_BITS-1:0] blink_count_reg, blink_count_next;
    logic [15:0]           press_count_reg, press_count_next;
    logic                  done_phase_reg,  done_phase_next;
    logic [6:0]            led_level_reg,   led_level_next;
    color_t                led_color_reg,   led_color_next;
    logic                  clear_next;

    logic [BLINK_BITS-1:0] mask_ext;
    mode_t                 cur_mode;

    assign cur_mode = (link_mode_reg <= MODE_LAST) ? link_mode_reg : MODE_IDLE;
    assign mask_ext = BLINK_BITS'(mode_mask(cur_mode));

    always_comb begin
        link_mode_next   = link_mode_reg;
        saved_mode_next  = saved_mode_reg;
        tick_phase_next  = tick_phase_reg;
        blink_count_next = blink_count_reg;
        press_count_next = press_count_reg;
        done_phase_next  = done_phase_reg;
        led_level_next   = led_level_reg;
        led_color_next   = led_color_reg;
        clear_next       = 1'b0;

        unique case (item.kind)
            KIND_SET: begin
                if (item.new_mode <= MODE_LAST) begin
                    link_mode_next = mode_t'(item.new_mode);
                end
            end
            KIND_TICK: begin
                led_color_next = mode_color(cur_mode);
                if (tick_phase_reg == item.timer_flag) begin
                    if (!done_phase_reg) begin
                        if (item.button_level) begin
                            if (press_count_reg == '0) begin
                                saved_mode_next = link_mode_reg;
                            end
                            if (press_count_reg != COUNT_MAX) begin
                                press_count_next = press_count_reg + 16'd1;
                            end
                            link_mode_next = MODE_PRESS;
                        end else if (press_count_reg != '0) begin
                            // restore only on release
                            press_count_next = '0;
                            link_mode_next   = saved_mode_reg;
                        end
                        if (press_count_next > hold_ticks_reg) begin
                            clear_next       = 1'b1;
                            press_count_next = '0;
                            done_phase_next  = 1'b1;
                        end
                    end
                    if (done_phase_next) begin
                        press_count_next = press_count_next + 16'd1;
                        link_mode_next   = MODE_DONE;
                        if (press_count_next > DONE_LIMIT) begin
                            done_phase_next  = 1'b0;
                            link_mode_next   = MODE_PAIRING;
                            press_count_next = '0;
                        end
                    end
                    blink_count_next = blink_count_reg + BLINK_ONE;
                    tick_phase_next  = ~item.timer_flag;
                    led_level_next   = ((blink_count_next & mask_ext) == mask_ext)
                                       ? FULL_ON : FULL_OFF;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_ticks_reg <= HOLD_RESET;
        end else if (cfg_we) begin
            hold_ticks_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_mode_reg   <= MODE_IDLE;
            saved_mode_reg  <= MODE_IDLE;
            tick_phase_reg  <= 1'b0;
            blink_count_reg <= '0;
            press_count_reg <= '0;
            done_phase_reg  <= 1'b0;
            led_level_reg   <= FULL_OFF;
            led_color_reg   <= COLOR_BLUE;
        end else if (item_fire) begin
            link_mode_reg   <= link_mode_next;
            saved_mode_reg  <= saved_mode_next;
            tick_phase_reg  <= tick_phase_next;
            blink_count_reg <= blink_count_next;
            press_count_reg <= press_count_next;
            done_phase_reg  <= done_phase_next;
            led_level_reg   <= led_level_next;
            led_color_reg   <= led_color_next;
        end
    end

    assign result.brightness  = led_level_next;
    assign result.color       = led_color_next;
    assign result.clear_owner = clear_next;
    assign result.mode        = link_mode_next;

    // clear pulse opens a done indicator window whenever DONE_TICKS is nonzero
    a_clear_enters_done: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && clear_next |=> done_phase_reg)
        else $error("clear_owner without done phase");

    // indicator counter never runs past its limit
    a_done_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        done_phase_reg |-> press_count_reg <= DONE_LIMIT)
        else $error("done phase count overrun");

    // state only moves on a presented item
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !item_fire |=> $stable(press_count_reg) && $stable(blink_count_reg))
        else $error("state changed without an item");

    // set items never touch the LED or blink state
    a_set_keeps_led: assert property (@(posedge aclk) disable iff (!aresetn)
        item_fire && item.kind == KIND_SET |=> $stable(blink_count_reg)
            && $stable(led_level_reg))
        else $error("set item altered LED state");

endmodule

>>> sv/status_led_and_button_hold.sv
// ----------------------------------------------------------------------------
// status_led_and_button_hold
// Status LED and long-press controller: input register, state core, result register.
// ----------------------------------------------------------------------------
// Items pass the input register, then the result register; m_ready can stall both.
// Throughput: 1 item per cycle unless m_ready stalls; an empty input still loads.
// State is updated by the core as the item leaves the input register.
// Reset (aresetn low, synchronous): both stages empty, mode idle, hold_ticks 100,
// LED off and blue, counters cleared.
module status_led_and_button_hold import slbh_pkg::*; #(
    parameter int BLINK_BITS = 8,
    parameter int DONE_TICKS = 5
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic        s_timer_flag,
    input  logic        s_button_level,
    input  logic [2:0]  s_new_mode,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_brightness,
    output logic [1:0]  m_color,
    output logic        m_clear_owner,
    output logic [2:0]  m_mode
);

    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_result_reg;
    result_t core_result;
    logic    advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.kind         <= kind_t'(s_kind);
            in_item_reg.timer_flag   <= s_timer_flag;
            in_item_reg.button_level <= s_button_level;
            in_item_reg.new_mode     <= s_new_mode;
        end
    end

    slbh_core #(
        .BLINK_BITS (BLINK_BITS),
        .DONE_TICKS (DONE_TICKS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item_fire (advance),
        .item      (in_item_reg),
        .result    (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_result_reg <= core_result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_brightness  = out_result_reg.brightness;
    assign m_color       = out_result_reg.color;
    assign m_clear_owner = out_result_reg.clear_owner;
    assign m_mode        = out_result_reg.mode;

endmodule

>>> bench/status_led_and_button_hold_tb.sv
// ----------------------------------------------------------------------------
// status_led_and_button_hold_tb
// Self-checking bench for the status LED / long-press controller. A queue of
// pending items feeds a clocked driver. Each item is predicted when it is
// accepted, and a clocked monitor checks every result field against the oldest
// prediction. Phases change hold_ticks and the idling on both channels.
// ----------------------------------------------------------------------------
module status_led_and_button_hold_tb;
    import slbh_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BLINK_BITS = 8;
    localparam int DONE_TICKS = 5;
    localparam int STALL_LIMIT = 4000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int LONG_HOLD_ITEMS = 60;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = 1'b0;
    logic        s_timer_flag = 1'b0;
    logic        s_button_level = 1'b0;
    logic [2:0]  s_new_mode = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [6:0]  m_brightness;
    logic [1:0]  m_color;
    logic        m_clear_owner;
    logic [2:0]  m_mode;

    status_led_and_button_hold #(
        .BLINK_BITS(BLINK_BITS),
        .DONE_TICKS(DONE_TICKS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_timer_flag  (s_timer_flag),
        .s_button_level(s_button_level),
        .s_new_mode    (s_new_mode),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_brightness  (m_brightness),
        .m_color       (m_color),
        .m_clear_owner (m_clear_owner),
        .m_mode        (m_mode)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // LED controller state, mirrored
    mode_t                 link_st = MODE_IDLE;
    mode_t                 saved_st = MODE_IDLE;
    logic                  phase_st = 1'b0;
    logic [BLINK_BITS-1:0] blink_st = '0;
    int unsigned           press_st = 0;
    logic                  done_st = 1'b0;
    logic [6:0]            level_st = FULL_OFF;
    color_t                color_st = COLOR_BLUE;
    logic [15:0]           hold_st = HOLD_RESET;

    item_t   pending_items[$];
    result_t led_expected[$];
    item_t   cur_item;
    logic    gen_phase = 1'b0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    bit      pressure_req = 1'b0;
    bit      pressure_done = 1'b0;
    int      stall_left = 0;
    int      idle_cycles = 0;
    int      errors = 0;
    int      items_in = 0;
    int      results_out = 0;
    int      clears_seen = 0;
    logic [5:0] modes_seen = '0;

    task automatic led_step(input item_t it, output result_t r);
        logic [BLINK_BITS-1:0] mask;
        logic                  clr;
        clr = 1'b0;
        mask = '0;
        if (it.kind == KIND_SET) begin
            if (it.new_mode <= MODE_LAST)
                link_st = mode_t'(it.new_mode);
        end else begin
            case (link_st)
                MODE_PAIRING: begin
                    mask = 'h08; color_st = COLOR_BLUE;
                end
                MODE_CONNECTED: begin
                    mask = 'h00; color_st = COLOR_BLUE;
                end
                MODE_FAULT: begin
                    mask = 'h00; color_st = COLOR_RED;
                end
                MODE_PRESS: begin
                    mask = 'h02; color_st = COLOR_GREEN;
                end
                MODE_DONE: begin
                    mask = 'h01; color_st = COLOR_WHITE;
                end
                default: begin
                    mask = 'h04; color_st = COLOR_BLUE;
                end
            endcase
            if (it.timer_flag == phase_st) begin
                if (!done_st) begin
                    if (it.button_level) begin
                        if (press_st == 0)
                            saved_st = link_st;
                        if (press_st < COUNT_MAX)
                            press_st++;
                        link_st = MODE_PRESS;
                    end else if (press_st != 0) begin
                        press_st = 0;
                        link_st = saved_st;
                    end
                    if (press_st > hold_st) begin
                        clr = 1'b1;
                        press_st = 0;
                        done_st = 1'b1;
                    end
                end
                // done indicator shows for DONE_TICKS ticks, then pairing
                if (done_st) begin
                    press_st++;
                    link_st = MODE_DONE;
                    if (press_st > DONE_TICKS) begin
                        done_st = 1'b0;
                        link_st = MODE_PAIRING;
                        press_st = 0;
                    end
                end
                blink_st = blink_st + 1'b1;
                phase_st = ~it.timer_flag;
                level_st = ((blink_st & mask) == mask) ? FULL_ON : FULL_OFF;
            end
        end
        r.brightness = level_st;
        r.color = color_st;
        r.clear_owner = clr;
        r.mode = link_st;
    endtask

    // stale ticks reuse the old flag and leave the phase alone
    task automatic add_tick(input bit btn, input bit stale);
        item_t it;
        it.kind = KIND_TICK;
        it.timer_flag = stale ? ~gen_phase : gen_phase;
        it.button_level = btn;
        it.new_mode = 3'($urandom_range(0, 7));
        if (!stale)
            gen_phase = ~gen_phase;
        pending_items.push_back(it);
    endtask

    task automatic add_set(input logic [2:0] m);
        item_t it;
        it.kind = KIND_SET;
        it.timer_flag = 1'($urandom_range(0, 1));
        it.button_level = 1'($urandom_range(0, 1));
        it.new_mode = m;
        pending_items.push_back(it);
    endtask

    // mostly clean press/release runs on a toggling timer, some noise
    task automatic add_random(input int n, input int hold);
        int  sel;
        int  run_left;
        bit  btn;
        run_left = 0;
        btn = 1'b0;
        for (int i = 0; i < n; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                add_set(3'($urandom_range(0, 7)));
            end else if (sel < 14) begin
                add_tick(1'($urandom_range(0, 1)), 1'b1);
            end else begin
                if (run_left == 0) begin
                    btn = ~btn;
                    run_left = btn ? $urandom_range(1, hold + 10) : $urandom_range(1, 6);
                end
                add_tick(btn, 1'b0);
                run_left--;
            end
        end
    endtask

    task automatic cfg_write(input logic [15:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        hold_st = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        do
            @(negedge aclk);
        while (pending_items.size() != 0 || s_valid || led_expected.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_idling(input int profile);
        @(negedge aclk);
        case (profile)
            1: begin
                send_idle_pct = 53; recv_stall_pct = 0;
            end
            2: begin
                send_idle_pct = 0; recv_stall_pct = 53;
            end
            3: begin
                send_idle_pct = 32; recv_stall_pct = 32;
            end
            default: begin
                send_idle_pct = 0; recv_stall_pct = 0;
            end
        endcase
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            errors++;
        end
    endtask

    // sender
    always @(posedge aclk) begin
        result_t r;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                led_step(cur_item, r);
                led_expected.push_back(r);
                items_in++;
            end
            if (!s_valid || s_ready) begin
                if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    s_kind <= cur_item.kind;
                    s_timer_flag <= cur_item.timer_flag;
                    s_button_level <= cur_item.button_level;
                    s_new_mode <= cur_item.new_mode;
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                results_out++;
                if (m_clear_owner)
                    clears_seen++;
                if (m_mode <= MODE_LAST)
                    modes_seen[m_mode] = 1'b1;
                if (led_expected.size() == 0) begin
                    $display("%0t: result with nothing expected, actual mode %0d brightness %0d",
                             $time, m_mode, m_brightness);
                    errors++;
                end else begin
                    want = led_expected.pop_front();
                    check_field("brightness", want.brightness, m_brightness);
                    check_field("color", want.color, m_color);
                    check_field("clear_owner", want.clear_owner, m_clear_owner);
                    check_field("mode", want.mode, m_mode);
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else if (pressure_req && !pressure_done) begin
                stall_left <= PRESSURE_CYCLES;
                pressure_done <= 1'b1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        int holds[8];
        holds = '{0, 3, 1, 7, 2, 15, 5, 0};
        holds[7] = $urandom_range(0, 24);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        set_idling(0);

        // all modes, ignored modes, stale tick, short press and release
        add_set(MODE_PAIRING);  add_tick(1'b0, 1'b0);
        add_set(MODE_CONNECTED);
        add_tick(1'b1, 1'b0);   add_tick(1'b1, 1'b0);   add_tick(1'b0, 1'b0);
        add_set(MODE_FAULT);    add_tick(1'b0, 1'b0);
        add_set(MODE_DONE);     add_tick(1'b0, 1'b0);
        add_set(MODE_PRESS);    add_tick(1'b0, 1'b0);
        add_set(3'd6);          add_set(3'd7);
        add_tick(1'b1, 1'b1);
        add_set(MODE_IDLE);     add_tick(1'b0, 1'b0);
        drain();

        // zero hold: press clears, done indicator, held press clears again, release in done
        cfg_write(16'd0);
        add_tick(1'b1, 1'b0);
        repeat (6) add_tick(1'b1, 1'b0);
        add_tick(1'b0, 1'b0);
        drain();

        for (int p = 0; p < 8; p++) begin
            cfg_write(16'(holds[p]));
            set_idling(p % 4);
            add_random(200, holds[p]);
            if (p == 0) begin
                @(negedge aclk);
                pressure_req = 1'b1;
            end
            drain();
        end

        // long press at the top hold value never clears the owner
        cfg_write(16'hFFFF);
        set_idling(0);
        add_set(MODE_CONNECTED);
        repeat (LONG_HOLD_ITEMS) add_tick(1'b1, 1'b0);
        add_tick(1'b0, 1'b0);
        add_tick(1'b0, 1'b0);
        drain();

        if (led_expected.size() != 0)
            errors++;
        $display("Covered %0d items / %0d results, %0d owner clears, modes seen %b.",
                 items_in, results_out, clears_seen, modes_seen);
        $display("Hold values 0..65535, four idling profiles, one long receiver stall.");
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("%0d failures", errors);
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
